// ===== hw/rtl/wpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsd_pkg
// Shared types, codes and helpers for the weld pulse sync distributor.
// ----------------------------------------------------------------------------
package wpsd_pkg;

    localparam int PHASE_FRACTION_BITS = 24;
    localparam int TIMER_BITS          = 16;
    localparam int PHASE_W             = PHASE_FRACTION_BITS + 1;
    localparam int DWELL_W             = 16;
    localparam int POS_W               = 8;
    localparam int ADDR_W              = 5;
    localparam int DATA_W              = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ARC_MODE       = 3'd0;
    localparam logic [2:0] REG_VC_MODE        = 3'd1;
    localparam logic [2:0] REG_TRAVEL_MODE    = 3'd2;
    localparam logic [2:0] REG_WIREFEED_MODE  = 3'd3;
    localparam logic [2:0] REG_WIREPOS_MODE   = 3'd4;
    localparam logic [2:0] REG_GAIN_DELAY     = 3'd5;
    localparam logic [2:0] REG_USE_KPP        = 3'd6;
    localparam logic [2:0] REG_HEAD_GAIN_MUTE = 3'd7;

    localparam logic [1:0] ARC_STRAIGHT = 2'd0;
    localparam logic [1:0] ARC_PULSE    = 2'd1;
    localparam logic [1:0] ARC_OSC      = 2'd2;
    localparam logic [1:0] ARC_OSC_IO   = 2'd3;

    localparam logic [1:0] AVC_CONT      = 2'd0;
    localparam logic [1:0] AVC_BG_LOCKED = 2'd1;
    localparam logic [1:0] AVC_FG_LOCKED = 2'd2;
    localparam logic [1:0] AVC_LOCKED    = 2'd3;

    localparam logic [1:0] FOL_STRAIGHT = 2'd0;
    localparam logic [1:0] FOL_PULSE    = 2'd1;
    localparam logic [1:0] FOL_IO       = 2'd2;

    localparam logic [1:0] SYNC_BG  = 2'd0;
    localparam logic [1:0] SYNC_FG  = 2'd1;
    localparam logic [1:0] SYNC_IN  = 2'd2;
    localparam logic [1:0] SYNC_OUT = 2'd3;
    localparam logic [2:0] AVC_SYNC_AVG = 3'd4;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_SET_GAIN  = 3'd1;
    localparam logic [2:0] CMD_SET_SAT   = 3'd2;
    localparam logic [2:0] CMD_ZERO_GAIN = 3'd3;
    localparam logic [2:0] CMD_ZERO_SAT  = 3'd4;

    localparam logic [POS_W-1:0] POS_IN = POS_W'(1);

    typedef enum logic [1:0] {
        OSC_NONE = 2'd0,
        OSC_IN   = 2'd1,
        OSC_OUT  = 2'd2
    } osc_phase_t;

    typedef struct packed {
        logic [1:0]  arc_mode;
        logic [1:0]  vc_mode;
        logic [1:0]  travel_mode;
        logic [1:0]  wirefeed_mode;
        logic [1:0]  wirepos_mode;
        logic [15:0] gain_delay_ticks;
        logic        use_kpp;
        logic        head_gain_mute;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        arc_mode:         2'd0,
        vc_mode:          2'd0,
        travel_mode:      2'd0,
        wirefeed_mode:    2'd0,
        wirepos_mode:     2'd0,
        gain_delay_ticks: 16'd63,
        use_kpp:          1'b1,
        head_gain_mute:   1'b0
    };

    typedef struct packed {
        logic [PHASE_W-1:0] pulse_step;
        logic [PHASE_W-1:0] pulse_width;
        logic               osc_sync_enable;
        logic [POS_W-1:0]   osc_position;
        logic [DWELL_W-1:0] dwell_in_ticks;
        logic [DWELL_W-1:0] dwell_out_ticks;
        logic               motor_ready;
        logic               command_slot_free;
    } item_t;

    typedef struct packed {
        logic [1:0] arc_sync;
        logic [1:0] travel_sync;
        logic [1:0] wirefeed_sync;
        logic [1:0] wirepos_sync;
        logic [2:0] avc_sync;
        logic       gain_enable;
        logic       bang_gain_enable;
        logic [2:0] gain_command;
        logic       avc_lock_flag;
    } result_t;

    // saturate a 16-bit tick count to the timer width
    function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [15:0] v);
        logic [15:0] hi;
        hi = v >> TIMER_BITS;
        if (hi != 16'd0)
            return {TIMER_BITS{1'b1}};
        return TIMER_BITS'(v);
    endfunction

endpackage

// ===== hw/rtl/wpsd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// wpsd_apb_regs
// APB register file holding the mode and gain settings.
// ----------------------------------------------------------------------------
module wpsd_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wpsd_pkg::ADDR_W-1:0]   paddr,
    input  logic [wpsd_pkg::DATA_W-1:0]   pwdata,
    output logic [wpsd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output wpsd_pkg::cfg_t                cfg
);
    import wpsd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ARC_MODE:       cfg_next.arc_mode         = pwdata[1:0];
                REG_VC_MODE:        cfg_next.vc_mode          = pwdata[1:0];
                REG_TRAVEL_MODE:    cfg_next.travel_mode      = pwdata[1:0];
                REG_WIREFEED_MODE:  cfg_next.wirefeed_mode    = pwdata[1:0];
                REG_WIREPOS_MODE:   cfg_next.wirepos_mode     = pwdata[1:0];
                REG_GAIN_DELAY:     cfg_next.gain_delay_ticks = pwdata[15:0];
                REG_USE_KPP:        cfg_next.use_kpp          = pwdata[0];
                REG_HEAD_GAIN_MUTE: cfg_next.head_gain_mute   = pwdata[0];
                default:            cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ARC_MODE:       prdata = DATA_W'(cfg_reg.arc_mode);
            REG_VC_MODE:        prdata = DATA_W'(cfg_reg.vc_mode);
            REG_TRAVEL_MODE:    prdata = DATA_W'(cfg_reg.travel_mode);
            REG_WIREFEED_MODE:  prdata = DATA_W'(cfg_reg.wirefeed_mode);
            REG_WIREPOS_MODE:   prdata = DATA_W'(cfg_reg.wirepos_mode);
            REG_GAIN_DELAY:     prdata = DATA_W'(cfg_reg.gain_delay_ticks);
            REG_USE_KPP:        prdata = DATA_W'(cfg_reg.use_kpp);
            REG_HEAD_GAIN_MUTE: prdata = DATA_W'(cfg_reg.head_gain_mute);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/wpsd_core.sv =====
// ----------------------------------------------------------------------------
// wpsd_core
// Tick state (pulse phase, dwell tracker, gain delay, command flags) and the
// single-pass sync and gain logic for one tick.
// ----------------------------------------------------------------------------
module wpsd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  wpsd_pkg::cfg_t    cfg,
    input  wpsd_pkg::item_t   item,
    input  logic              advance,
    output wpsd_pkg::result_t res
);
    import wpsd_pkg::*;

    localparam logic [PHASE_FRACTION_BITS+1:0] PHASE_ONE =
        {2'b01, {PHASE_FRACTION_BITS{1'b0}}};

    logic [PHASE_FRACTION_BITS-1:0] pulse_phase_reg, pulse_phase_next;
    osc_phase_t                     osc_phase_reg, osc_phase_next;
    logic [POS_W-1:0]               last_pos_reg, last_pos_next;
    logic [TIMER_BITS-1:0]          dwell_count_reg, dwell_count_next;
    logic                           dwell_expired_reg, dwell_expired_next;
    logic                           delay_request_reg, delay_request_next;
    logic [TIMER_BITS-1:0]          delay_count_reg, delay_count_next;
    logic                           delay_done_reg, delay_done_next;
    logic                           gain_sent_reg, gain_sent_next;
    logic                           zero_gain_sent_reg, zero_gain_sent_next;

    osc_phase_t                     ph1;
    logic [TIMER_BITS-1:0]          cnt1;
    logic                           exp1;
    logic [PHASE_FRACTION_BITS+1:0] phase_sum;
    logic [TIMER_BITS-1:0]          delay_limit;
    logic [1:0]                     arc;
    logic                           gain;

    function automatic logic [1:0] follower(input logic [1:0] mode,
                                            input osc_phase_t ph);
        logic [1:0] s;
        s = SYNC_BG;
        if (mode == FOL_PULSE && ph != OSC_NONE)
            s = SYNC_FG;
        else if (mode == FOL_IO && ph == OSC_IN)
            s = SYNC_IN;
        else if (mode == FOL_IO && ph == OSC_OUT)
            s = SYNC_OUT;
        return s;
    endfunction

    // dwell tracking
    always_comb
    begin
        ph1                = osc_phase_reg;
        cnt1               = dwell_count_reg;
        exp1               = dwell_expired_reg;
        osc_phase_next     = osc_phase_reg;
        dwell_count_next   = dwell_count_reg;
        dwell_expired_next = dwell_expired_reg;
        last_pos_next      = last_pos_reg;
        if (item.osc_sync_enable)
        begin
            if (item.osc_position != last_pos_reg)
            begin
                if (item.osc_position == POS_IN)
                begin
                    ph1  = OSC_IN;
                    cnt1 = sat_timer(item.dwell_in_ticks);
                end
                else
                begin
                    ph1  = OSC_OUT;
                    cnt1 = sat_timer(item.dwell_out_ticks);
                end
                exp1 = 1'b0;
            end
            osc_phase_next     = exp1 ? OSC_NONE : ph1;
            dwell_count_next   = cnt1;
            dwell_expired_next = exp1;
            if (osc_phase_next != OSC_NONE)
            begin
                if (cnt1 != '0)
                    dwell_count_next = cnt1 - TIMER_BITS'(1);
                if (dwell_count_next == '0)
                    dwell_expired_next = 1'b1;
            end
            last_pos_next = item.osc_position;
        end
    end

    // arc sync and pulse generator
    assign phase_sum = (PHASE_FRACTION_BITS+2)'(pulse_phase_reg)
                     + (PHASE_FRACTION_BITS+2)'(item.pulse_step);

    always_comb
    begin
        pulse_phase_next = pulse_phase_reg;
        arc              = SYNC_BG;
        unique case (cfg.arc_mode)
            ARC_PULSE:
            begin
                if (item.pulse_step != '0)
                begin
                    if (phase_sum >= PHASE_ONE)
                        pulse_phase_next = '0;
                    else
                        pulse_phase_next = phase_sum[PHASE_FRACTION_BITS-1:0];
                    arc = ({1'b0, pulse_phase_next} >= item.pulse_width) ? SYNC_BG
                                                                         : SYNC_FG;
                end
            end
            ARC_OSC:      arc = (osc_phase_next != OSC_NONE) ? SYNC_FG : SYNC_BG;
            ARC_OSC_IO:   arc = follower(FOL_IO, osc_phase_next);
            ARC_STRAIGHT: arc = SYNC_BG;
            default:      arc = SYNC_BG;
        endcase
    end

    // voltage control sync, gain enables, commands and on-delay
    assign delay_limit = sat_timer(cfg.gain_delay_ticks);

    always_comb
    begin
        res                 = '0;
        res.arc_sync        = arc;
        res.travel_sync     = follower(cfg.travel_mode, osc_phase_next);
        res.wirefeed_sync   = follower(cfg.wirefeed_mode, osc_phase_next);
        res.wirepos_sync    = follower(cfg.wirepos_mode, osc_phase_next);
        gain                = 1'b1;
        res.bang_gain_enable = 1'b1;
        delay_request_next  = delay_request_reg;

        unique case (cfg.vc_mode)
            AVC_BG_LOCKED:
            begin
                if (cfg.arc_mode != ARC_STRAIGHT)
                begin
                    if (arc == SYNC_BG)
                    begin
                        gain                 = 1'b0;
                        res.bang_gain_enable = 1'b0;
                        delay_request_next   = 1'b0;
                    end
                    else
                    begin
                        gain               = delay_done_reg;
                        delay_request_next = 1'b1;
                    end
                end
                res.avc_sync = (cfg.arc_mode == ARC_OSC_IO && arc == SYNC_BG)
                             ? AVC_SYNC_AVG : {1'b0, arc};
            end
            AVC_FG_LOCKED:
            begin
                gain                 = (arc == SYNC_BG);
                res.bang_gain_enable = gain;
                res.avc_sync         = 3'd0;
            end
            AVC_LOCKED:
            begin
                res.avc_lock_flag    = 1'b1;
                gain                 = 1'b0;
                res.bang_gain_enable = 1'b0;
                res.avc_sync         = 3'd0;
            end
            default:
            begin
                res.avc_sync = (cfg.arc_mode == ARC_STRAIGHT) ? {1'b0, SYNC_FG}
                                                              : {1'b0, arc};
            end
        endcase
        res.gain_enable = gain;

        res.gain_command    = CMD_NONE;
        gain_sent_next      = gain_sent_reg;
        zero_gain_sent_next = zero_gain_sent_reg;
        priority if (cfg.head_gain_mute)
        begin
            gain_sent_next      = 1'b1;
            zero_gain_sent_next = 1'b1;
        end
        else if (!item.motor_ready)
        begin
            gain_sent_next      = 1'b0;
            zero_gain_sent_next = 1'b0;
        end
        else if (item.command_slot_free)
        begin
            if (!gain && !zero_gain_sent_reg)
            begin
                res.gain_command    = cfg.use_kpp ? CMD_ZERO_GAIN : CMD_ZERO_SAT;
                zero_gain_sent_next = 1'b1;
                gain_sent_next      = 1'b0;
            end
            else if (gain && !gain_sent_reg)
            begin
                res.gain_command    = cfg.use_kpp ? CMD_SET_GAIN : CMD_SET_SAT;
                gain_sent_next      = 1'b1;
                zero_gain_sent_next = 1'b0;
            end
        end

        if (!delay_request_next)
        begin
            delay_count_next = '0;
            delay_done_next  = 1'b0;
        end
        else
        begin
            delay_count_next = delay_count_reg;
            if (delay_count_reg < delay_limit)
                delay_count_next = delay_count_reg + TIMER_BITS'(1);
            delay_done_next = (delay_count_next >= delay_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_phase_reg    <= '0;
            osc_phase_reg      <= OSC_NONE;
            last_pos_reg       <= '0;
            dwell_count_reg    <= '0;
            dwell_expired_reg  <= 1'b0;
            delay_request_reg  <= 1'b0;
            delay_count_reg    <= '0;
            delay_done_reg     <= 1'b0;
            gain_sent_reg      <= 1'b0;
            zero_gain_sent_reg <= 1'b0;
        end
        else if (advance)
        begin
            pulse_phase_reg    <= pulse_phase_next;
            osc_phase_reg      <= osc_phase_next;
            last_pos_reg       <= last_pos_next;
            dwell_count_reg    <= dwell_count_next;
            dwell_expired_reg  <= dwell_expired_next;
            delay_request_reg  <= delay_request_next;
            delay_count_reg    <= delay_count_next;
            delay_done_reg     <= delay_done_next;
            gain_sent_reg      <= gain_sent_next;
            zero_gain_sent_reg <= zero_gain_sent_next;
        end
    end

    a_dwell_done: assert property (@(posedge clk) disable iff (!rst_n)
        (osc_phase_reg != OSC_NONE && dwell_count_reg == '0) |-> dwell_expired_reg)
        else $error("active dwell with zero count not marked expired");

    a_delay_done_req: assert property (@(posedge clk) disable iff (!rst_n)
        delay_done_reg |-> delay_request_reg)
        else $error("gain delay done without request");

    a_delay_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !delay_request_reg |-> (delay_count_reg == '0))
        else $error("gain delay count running without request");

endmodule

// ===== hw/rtl/weld_pulse_sync_distributor_unit.sv =====
// ----------------------------------------------------------------------------
// weld_pulse_sync_distributor_unit
// Per-tick sync and gain distributor for a pulsed welding head.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one control tick per transfer:
//   pulse step and width, oscillator position and dwell times, motor status.
//   Output channel (out_valid / out_stall) returns one result per tick: sync
//   codes for arc, travel, wire feed, wire position and voltage control, gain
//   enables, a gain command and the lock flag.
//   Mode and gain settings sit in an APB register file at byte address
//   4 * index; write them only while no tick is in flight.
//   Path: a tick passes the input register, then the result register, where
//   out_valid rises; the tick state updates as the result is loaded.
//   Throughput: one tick per cycle, sustained while out_stall is low.
//   Stall: when out_stall holds a waiting result, an empty input register
//   still takes one more tick, then in_stall rises until the result is taken.
//   Reset: both stages empty, all tick state zero, registers at defaults
//   (gain delay 63 ticks, proportional gain commands).
// ----------------------------------------------------------------------------
module weld_pulse_sync_distributor_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wpsd_pkg::PHASE_W-1:0]         pulse_step,
    input  logic [wpsd_pkg::PHASE_W-1:0]         pulse_width,
    input  logic                                 osc_sync_enable,
    input  logic [wpsd_pkg::POS_W-1:0]           osc_position,
    input  logic [wpsd_pkg::DWELL_W-1:0]         dwell_in_ticks,
    input  logic [wpsd_pkg::DWELL_W-1:0]         dwell_out_ticks,
    input  logic                                 motor_ready,
    input  logic                                 command_slot_free,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           arc_sync,
    output logic [1:0]                           travel_sync,
    output logic [1:0]                           wirefeed_sync,
    output logic [1:0]                           wirepos_sync,
    output logic [2:0]                           avc_sync,
    output logic                                 gain_enable,
    output logic                                 bang_gain_enable,
    output logic [2:0]                           gain_command,
    output logic                                 avc_lock_flag,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wpsd_pkg::ADDR_W-1:0]          paddr,
    input  logic [wpsd_pkg::DATA_W-1:0]          pwdata,
    output logic [wpsd_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import wpsd_pkg::*;

    cfg_t    cfg;
    item_t   item_reg, item_next;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    load_in;

    wpsd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wpsd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    always_comb
    begin
        item_next.pulse_step        = pulse_step;
        item_next.pulse_width       = pulse_width;
        item_next.osc_sync_enable   = osc_sync_enable;
        item_next.osc_position      = osc_position;
        item_next.dwell_in_ticks    = dwell_in_ticks;
        item_next.dwell_out_ticks   = dwell_out_ticks;
        item_next.motor_ready       = motor_ready;
        item_next.command_slot_free = command_slot_free;
        in_valid_next  = load_in || in_stall;
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            item_reg <= item_next;
        if (advance)
            res_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign arc_sync         = res_reg.arc_sync;
    assign travel_sync      = res_reg.travel_sync;
    assign wirefeed_sync    = res_reg.wirefeed_sync;
    assign wirepos_sync     = res_reg.wirepos_sync;
    assign avc_sync         = res_reg.avc_sync;
    assign gain_enable      = res_reg.gain_enable;
    assign bang_gain_enable = res_reg.bang_gain_enable;
    assign gain_command     = res_reg.gain_command;
    assign avc_lock_flag    = res_reg.avc_lock_flag;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline slot");

    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick did not reach the result register");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(res_reg)))
        else $error("waiting result lost or overwritten");

endmodule
